[rtl/core/acfb_pkg.sv]
// ----------------------------------------------------------------------------
// acfb_pkg
// Shared types, register indexes and AES round functions for the CFB-128
// byte stream.
// ----------------------------------------------------------------------------
package acfb_pkg;

  localparam int unsigned MaxRounds = 14;

  localparam logic [2:0] RegKey0   = 3'd0;
  localparam logic [2:0] RegKey1   = 3'd1;
  localparam logic [2:0] RegKey2   = 3'd2;
  localparam logic [2:0] RegKey3   = 3'd3;
  localparam logic [2:0] RegKeyLen = 3'd4;
  localparam logic [2:0] RegIvHigh = 3'd5;
  localparam logic [2:0] RegIvLow  = 3'd6;

  localparam logic [1:0] ModeAes128 = 2'd0;
  localparam logic [1:0] ModeAes192 = 2'd1;

  typedef struct packed {
    logic       exp_clear;
    logic       exp_step;
    logic [5:0] exp_idx;
    logic [3:0] rd_row;
    logic       ark0;
    logic       round_en;
    logic [3:0] round;
    logic       latch_in;
    logic       byte_op;
  } cmd_t;

  typedef struct packed {
    logic key_wr;
    logic exp_last;
    logic round_last;
    logic pos_zero;
  } status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // SubBytes, ShiftRows and, unless final, MixColumns; byte 0 in bits 127:120
  function automatic logic [127:0] enc_round(input logic [127:0] st, input logic final_rnd);
    logic [7:0] t [16];
    logic [7:0] s [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[st[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[4*c+r] = t[4*((c+r)&3)+r];
      end
    end
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = s[4*c];
        a1 = s[4*c+1];
        a2 = s[4*c+2];
        a3 = s[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        s[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        s[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        s[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        s[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[127-8*i -: 8] = s[i];
    end
    enc_round = res;
  endfunction

endpackage

[rtl/core/acfb_datapath.sv]
// ----------------------------------------------------------------------------
// acfb_datapath
// Configuration registers, key schedule with round key store, cipher state
// and byte XOR path.
// ----------------------------------------------------------------------------
module acfb_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [63:0]      cfg_data_i,
  input  logic             kind_i,
  input  logic [7:0]       data_in_i,
  input  logic             last_in_i,
  input  acfb_pkg::cmd_t   cmd_i,
  output acfb_pkg::status_t sts_o,
  output logic [7:0]       data_out_o,
  output logic             last_out_o
);

  logic [63:0]  key_q [4];
  logic [1:0]   mode_q;
  logic [127:0] fb_q;
  logic [3:0]   pos_q;
  logic [2:0]   j_q;
  logic [7:0]   rcon_q;
  logic [31:0]  win_q [8];
  logic [127:0] mem [16];
  logic [127:0] rk_q;
  logic         kind_q, last_q;
  logic [7:0]   din_q;
  logic [7:0]   dout_q;
  logic         last_out_q;

  logic [2:0]   nkm1;
  logic [3:0]   nrounds;
  logic [5:0]   total_m1;
  logic [255:0] key256;
  logic [31:0]  kword, t_w, new_w;
  logic         from_key;
  logic [7:0]   fb_byte, dout_d;

  always_comb begin
    unique case (mode_q)
      acfb_pkg::ModeAes128: begin nkm1 = 3'd3; nrounds = 4'd10; end
      acfb_pkg::ModeAes192: begin nkm1 = 3'd5; nrounds = 4'd12; end
      default:              begin nkm1 = 3'd7; nrounds = 4'd14; end
    endcase
  end

  assign total_m1 = {nrounds + 4'd1, 2'b00} - 6'd1;
  assign key256   = {key_q[0], key_q[1], key_q[2], key_q[3]};
  assign kword    = key256[{~cmd_i.exp_idx[2:0], 5'b00000} +: 32];
  assign from_key = cmd_i.exp_idx <= {3'b000, nkm1};

  always_comb begin
    t_w = win_q[0];
    if (j_q == 3'd0) begin
      t_w = acfb_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
    end else if (nkm1 == 3'd7 && j_q == 3'd4) begin
      t_w = acfb_pkg::sub_word(win_q[0]);
    end
    new_w = from_key ? kword : (win_q[nkm1] ^ t_w);
  end

  assign fb_byte = fb_q[{~pos_q, 3'b000} +: 8];
  assign dout_d  = din_q ^ fb_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      mode_q <= '0;
      fb_q   <= '0;
      pos_q  <= '0;
      j_q    <= '0;
      rcon_q <= 8'h01;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          acfb_pkg::RegKey0:   key_q[0] <= cfg_data_i;
          acfb_pkg::RegKey1:   key_q[1] <= cfg_data_i;
          acfb_pkg::RegKey2:   key_q[2] <= cfg_data_i;
          acfb_pkg::RegKey3:   key_q[3] <= cfg_data_i;
          acfb_pkg::RegKeyLen: mode_q   <= cfg_data_i[1:0];
          acfb_pkg::RegIvHigh: fb_q[127:64] <= cfg_data_i;
          acfb_pkg::RegIvLow: begin
            fb_q[63:0] <= cfg_data_i;
            pos_q      <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.exp_clear) begin
        j_q    <= '0;
        rcon_q <= 8'h01;
      end else if (cmd_i.exp_step) begin
        j_q <= (j_q == nkm1) ? 3'd0 : j_q + 3'd1;
        if (!from_key && j_q == 3'd0) rcon_q <= acfb_pkg::xtime(rcon_q);
      end
      if (cmd_i.ark0) begin
        fb_q <= fb_q ^ rk_q;
      end else if (cmd_i.round_en) begin
        fb_q <= acfb_pkg::enc_round(fb_q, sts_o.round_last) ^ rk_q;
      end else if (cmd_i.byte_op) begin
        fb_q[{~pos_q, 3'b000} +: 8] <= kind_q ? din_q : dout_d;
        pos_q <= pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      mem[cmd_i.exp_idx[5:2]][{~cmd_i.exp_idx[1:0], 5'b00000} +: 32] <= new_w;
      win_q[0] <= new_w;
      for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
    end
    rk_q <= mem[cmd_i.rd_row];
    if (cmd_i.latch_in) begin
      kind_q <= kind_i;
      din_q  <= data_in_i;
      last_q <= last_in_i;
    end
    if (cmd_i.byte_op) begin
      dout_q     <= dout_d;
      last_out_q <= last_q;
    end
  end

  assign sts_o.key_wr     = cfg_we_i && (cfg_idx_i <= acfb_pkg::RegKeyLen);
  assign sts_o.exp_last   = cmd_i.exp_idx == total_m1;
  assign sts_o.round_last = cmd_i.round == nrounds;
  assign sts_o.pos_zero   = pos_q == 4'd0;

  assign data_out_o = dout_q;
  assign last_out_o = last_out_q;

endmodule

[rtl/core/acfb_ctrl.sv]
// ----------------------------------------------------------------------------
// acfb_ctrl
// Sequencer for key expansion, block encryption and byte transactions.
// ----------------------------------------------------------------------------
module acfb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  acfb_pkg::status_t sts_i,
  output acfb_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StExpand = 3'd1;
  localparam logic [2:0] StLoad   = 3'd2;
  localparam logic [2:0] StArk    = 3'd3;
  localparam logic [2:0] StRound  = 3'd4;
  localparam logic [2:0] StByte   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] exp_idx_q, exp_idx_d;
  logic [3:0] round_q, round_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == StIdle) && !sts_i.key_wr;

  always_comb begin
    state_d     = state_q;
    exp_idx_d   = exp_idx_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.exp_idx  = exp_idx_q;
    cmd_o.round    = round_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.latch_in = 1'b1;
          state_d = sts_i.pos_zero ? StLoad : StByte;
        end
      end
      StExpand: begin
        cmd_o.exp_step = 1'b1;
        exp_idx_d = exp_idx_q + 6'd1;
        if (sts_i.exp_last) state_d = StIdle;
      end
      StLoad: begin
        cmd_o.rd_row = 4'd0;
        state_d = StArk;
      end
      StArk: begin
        cmd_o.ark0   = 1'b1;
        cmd_o.rd_row = 4'd1;
        round_d = 4'd1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        cmd_o.rd_row   = round_q + 4'd1;
        if (sts_i.round_last) state_d = StByte;
        else round_d = round_q + 4'd1;
      end
      StByte: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.byte_op = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (sts_i.key_wr) begin
      cmd_o.exp_clear = 1'b1;
      cmd_o.exp_step  = 1'b0;
      exp_idx_d = '0;
      state_d   = StExpand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StExpand;
      exp_idx_q   <= '0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_idx_q   <= exp_idx_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q) else $error("pending result dropped");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> (round_q != 4'd0 && round_q <= 4'(acfb_pkg::MaxRounds)))
    else $error("round counter out of range");

  a_key_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.key_wr |=> (state_q == StExpand && exp_idx_q == 6'd0))
    else $error("key write did not restart expansion");

endmodule

[rtl/core/aes_cfb128_byte_stream.sv]
// ----------------------------------------------------------------------------
// aes_cfb128_byte_stream
// Byte-serial AES CFB-128 encrypt/decrypt with 128/192/256-bit keys.
// ----------------------------------------------------------------------------
// A byte inside a block is accepted, then the XOR step loads the output
// register. The first byte of each block (position zero) runs the AES core
// first, one round per cycle.
// The XOR step waits while the previous result has not been taken.
// After reset and after every key or key length write, in_ready_o stays low
// while the schedule fills the round key store one word per cycle. The
// output register lets the next transaction in while a result waits.
module aes_cfb128_byte_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_in_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_out_o,
  output logic        last_out_o
);

  acfb_pkg::cmd_t    cmd;
  acfb_pkg::status_t sts;

  acfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  acfb_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .kind_i     (kind_i),
    .data_in_i  (data_in_i),
    .last_in_i  (last_in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .data_out_o (data_out_o),
    .last_out_o (last_out_o)
  );

endmodule

[test/aes_cfb128_byte_stream_tb.sv]
// ----------------------------------------------------------------------------
// aes_cfb128_byte_stream_tb
// Self-checking bench for the byte-serial AES CFB-128 stream. A directed table
// of bytes (known vectors, extremes, both directions) and a key length sweep
// are followed by random key, IV and byte sequences under three idling
// profiles. Every output transaction is compared with a local cipher model.
// ----------------------------------------------------------------------------
module aes_cfb128_byte_stream_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_in_i = '0;
  logic        last_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  data_out_o;
  logic        last_out_o;

  aes_cfb128_byte_stream uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_res_t;

  localparam logic KindEnc = 1'b0;
  localparam logic KindDec = 1'b1;

  // cipher model state
  logic [63:0]  key_w [4];
  logic [1:0]   key_len;
  logic [7:0]   fb [16];
  logic [3:0]   pos;
  logic [31:0]  rk [60];
  int unsigned  nr;

  byte_res_t    exp_q [$];
  int           errors = 0;
  int           cycles = 0;
  int unsigned  in_idle = 0, out_idle = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {acfb_pkg::SBOX[w[31:24]], acfb_pkg::SBOX[w[23:16]],
            acfb_pkg::SBOX[w[15:8]], acfb_pkg::SBOX[w[7:0]]};
  endfunction

  task automatic build_schedule();
    int unsigned nk, total;
    logic [31:0] t, rc;
    int kb;
    nk = (key_len == acfb_pkg::ModeAes128) ? 4 : (key_len == acfb_pkg::ModeAes192) ? 6 : 8;
    nr = nk + 6;
    total = 4 * (nr + 1);
    rc = 32'h0100_0000;
    for (int i = 0; i < nk; i++) begin
      t = '0;
      for (int k = 0; k < 4; k++) begin
        kb = 4 * i + k;
        t = {t[23:0], key_w[kb >> 3][63 - 8 * (kb & 7) -: 8]};
      end
      rk[i] = t;
    end
    for (int i = nk; i < total; i++) begin
      t = rk[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ rc;
        rc = {gmul2(rc[31:24]), 24'h0};
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      rk[i] = rk[i-nk] ^ t;
    end
  endtask

  function automatic void cipher_feedback();
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    for (int rnd = 0; rnd <= nr; rnd++) begin
      if (rnd > 0) begin
        for (int i = 0; i < 16; i++) t[i] = acfb_pkg::SBOX[fb[i]];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) fb[4*c+r] = t[4*((c+r)&3)+r];
        if (rnd != nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = fb[4*c]; a1 = fb[4*c+1]; a2 = fb[4*c+2]; a3 = fb[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            fb[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
            fb[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
            fb[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
            fb[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) fb[4*c+r] ^= rk[4*rnd+c][31-8*r -: 8];
    end
  endfunction

  function automatic byte_res_t cfb_byte(input logic k, input logic [7:0] d, input logic l);
    byte_res_t res;
    if (pos == 0) cipher_feedback();
    res.data = d ^ fb[pos];
    res.last = l;
    fb[pos] = k ? d : res.data;
    pos = pos + 4'd1;
    return res;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    key_len = acfb_pkg::ModeAes128;
    for (int i = 0; i < 16; i++) fb[i] = '0;
    pos = '0;
    build_schedule();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      acfb_pkg::RegKey0, acfb_pkg::RegKey1, acfb_pkg::RegKey2, acfb_pkg::RegKey3: begin
        key_w[idx] = val;
        build_schedule();
      end
      acfb_pkg::RegKeyLen: begin
        key_len = val[1:0];
        build_schedule();
      end
      acfb_pkg::RegIvHigh: for (int i = 0; i < 8; i++) fb[i] = val[63-8*i -: 8];
      acfb_pkg::RegIvLow: begin
        for (int i = 0; i < 8; i++) fb[8+i] = val[63-8*i -: 8];
        pos = '0;
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // one byte transaction; optional hard expectation checked against model
  task automatic send_byte(input logic k, input logic [7:0] d, input logic l,
                           input logic chk, input logic [7:0] want);
    byte_res_t r;
    while ($urandom_range(99) < in_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    r = cfb_byte(k, d, l);
    if (chk && r.data !== want) begin
      $display("%0t model vector: expected %h actual %h", $time, want, r.data);
      errors++;
    end
    exp_q.push_back(r);
    in_valid_i <= 1'b1;
    kind_i     <= k;
    data_in_i  <= d;
    last_in_i  <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    byte_res_t e;
    cycles <= cycles + 1;
    out_ready_i <= ($urandom_range(99) >= out_idle);
    if (out_valid_o && out_ready_i) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected transaction: actual %h/%b", $time, data_out_o, last_out_o);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (data_out_o !== e.data) begin
          $display("%0t data_out: expected %h actual %h", $time, e.data, data_out_o);
          errors++;
        end
        if (last_out_o !== e.last) begin
          $display("%0t last_out: expected %b actual %b", $time, e.last, last_out_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    logic       k;
    logic [7:0] d;
    logic       l;
    logic       chk;
    logic [7:0] want;
  } row_t;

  // zero key, zero IV: first keystream block is AES-128(0) = 66e94bd4...
  row_t dir_tab [] = '{
    '{KindEnc, 8'h00, 1'b0, 1'b1, 8'h66},
    '{KindEnc, 8'h00, 1'b0, 1'b1, 8'he9},
    '{KindEnc, 8'hff, 1'b0, 1'b1, 8'hb4},
    '{KindDec, 8'h00, 1'b1, 1'b1, 8'hd4},
    '{KindDec, 8'hff, 1'b0, 1'b0, 8'h00},
    '{KindEnc, 8'h80, 1'b1, 1'b0, 8'h00},
    '{KindDec, 8'h01, 1'b0, 1'b0, 8'h00},
    '{KindEnc, 8'h7f, 1'b0, 1'b0, 8'h00},
    '{KindEnc, 8'h55, 1'b0, 1'b0, 8'h00},
    '{KindDec, 8'haa, 1'b0, 1'b0, 8'h00},
    '{KindEnc, 8'h00, 1'b0, 1'b0, 8'h00},
    '{KindDec, 8'hff, 1'b0, 1'b0, 8'h00},
    '{KindEnc, 8'h12, 1'b0, 1'b0, 8'h00},
    '{KindDec, 8'h34, 1'b0, 1'b0, 8'h00},
    '{KindEnc, 8'h56, 1'b0, 1'b0, 8'h00},
    '{KindDec, 8'h78, 1'b1, 1'b0, 8'h00},
    '{KindEnc, 8'h9a, 1'b0, 1'b0, 8'h00},
    '{KindDec, 8'hbc, 1'b1, 1'b0, 8'h00}
  };

  task automatic random_keys();
    for (int i = 0; i < 4; i++) write_reg(3'(acfb_pkg::RegKey0 + i), {$urandom, $urandom});
    write_reg(acfb_pkg::RegKeyLen, 64'($urandom_range(3)));
    write_reg(acfb_pkg::RegIvHigh, {$urandom, $urandom});
    write_reg(acfb_pkg::RegIvLow, {$urandom, $urandom});
  endtask

  initial begin
    int n;
    logic k;
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i])
      send_byte(dir_tab[i].k, dir_tab[i].d, dir_tab[i].l, dir_tab[i].chk, dir_tab[i].want);
    drain();
    // extremes of key and mode, including the unused mode code three
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 4; i++)
        write_reg(3'(acfb_pkg::RegKey0 + i), (m & 1) ? '1 : '0);
      write_reg(acfb_pkg::RegKeyLen, 64'(m));
      write_reg(acfb_pkg::RegIvHigh, (m & 1) ? '0 : '1);
      write_reg(acfb_pkg::RegIvLow, (m & 2) ? '1 : '0);
      for (int j = 0; j < 18; j++) send_byte(j[0], j[0] ? 8'hff : 8'h00, j[1], 1'b0, 8'h00);
      drain();
      // rewrite only the high half: position is kept mid-block
      write_reg(acfb_pkg::RegIvHigh, {$urandom, $urandom});
      for (int j = 0; j < 3; j++) send_byte(KindEnc, 8'($urandom), 1'b0, 1'b0, 8'h00);
      drain();
    end
    write_reg(3'd7, '1);
    for (int ph = 0; ph < 3; ph++) begin
      in_idle  = (ph == 0) ? 32 : (ph == 1) ? 75 : 0;
      out_idle = (ph == 0) ? 75 : (ph == 1) ? 32 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        random_keys();
        n = $urandom_range(20, 40);
        k = 1'($urandom_range(1));
        for (int j = 0; j < n; j++)
          send_byte(($urandom_range(9) == 0) ? ~k : k, 8'($urandom), $urandom_range(7) == 0,
                    1'b0, 8'h00);
        drain();
      end
    end
    in_idle = 0;
    out_idle = 0;
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
